### design/acad_pkg.sv
`default_nettype none

package acad_pkg;

	// field widths
	localparam int JOY_W       = 2;
	localparam int AXIS_W      = 3;
	localparam int SAMPLE_W    = 16;
	localparam int ANALOG_W    = 9;

	// stream word layout
	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = 6;
	localparam int OUT_TDATA_W = 16;

	// per-axis reset calibration
	localparam logic signed [SAMPLE_W-1:0] LOW_RESET    = -16'sd10;
	localparam logic signed [SAMPLE_W-1:0] HIGH_RESET   = 16'sd10;
	localparam logic signed [SAMPLE_W-1:0] CENTER_RESET = 16'sd0;

	// analog scaling
	localparam logic [8:0] SCALE     = 9'd257;
	localparam logic [8:0] CLAMP_MAG = 9'd128;

	// quotient magnitude never exceeds 257, so nine restoring steps suffice
	localparam int         DIV_STEPS = 9;
	localparam int         DIV_CNT_W = 4;

	// controller -> datapath commands
	typedef struct packed {
		logic capture;   // latch input word, start memory read
		logic update;    // widen bounds, write back entry
		logic flags;     // direction flags, load divider
		logic div_step;  // one restoring divide step
		logic load_out;  // load result word into output register
	} acad_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic in_range;  // incoming word addresses a valid axis
		logic analog_en; // analog mode enabled
		logic div_last;  // current divide step is the final one
	} acad_sts_t;

endpackage

`default_nettype wire

### design/acad_ctrl.sv
`default_nettype none

module acad_ctrl
	import acad_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_axis_tvalid,
	output logic           s_axis_tready,
	output logic           m_axis_tvalid,
	input  wire logic      m_axis_tready,
	input  wire acad_sts_t sts,
	output acad_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_FLAGS,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_acc;
	logic   out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.capture  = in_acc;
		cmd.update   = (state_q == ST_UPDATE);
		cmd.flags    = (state_q == ST_FLAGS);
		cmd.div_step = (state_q == ST_DIVIDE);
		cmd.load_out = (state_q == ST_FINISH) && out_free;
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= sts.in_range ? ST_READ : ST_FINISH;
					end
				end
				ST_READ:   state_q <= ST_UPDATE;
				ST_UPDATE: state_q <= ST_FLAGS;
				ST_FLAGS: begin
					state_q <= sts.analog_en ? ST_DIVIDE : ST_FINISH;
				end
				ST_DIVIDE: begin
					if (sts.div_last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/acad_datapath.sv
`default_nettype none

module acad_datapath
	import acad_pkg::*;
#(
	parameter int NUM_JOYSTICKS     = 4,
	parameter int AXES_PER_JOYSTICK = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
	input  wire logic                   cfg_valid,
	input  wire logic                   cfg_data,
	input  wire acad_cmd_t              cmd,
	output acad_sts_t                   sts
);

	localparam int SLOTS  = NUM_JOYSTICKS * AXES_PER_JOYSTICK;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] lo;
		logic signed [SAMPLE_W-1:0] hi;
		logic signed [SAMPLE_W-1:0] ctr;
	} entry_t;

	// input word fields
	logic        [JOY_W-1:0]    in_joy;
	logic        [AXIS_W-1:0]   in_axis;
	logic                       in_inv;
	logic        [SLOT_W-1:0]   in_slot;

	// item registers
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       inv_q;
	logic                       oob_q;
	logic        [SLOT_W-1:0]   slot_q;
	logic                       analog_en_q;

	// calibration store
	entry_t                     mem [SLOTS];
	logic        [SLOTS-1:0]    valid_q;
	entry_t                     rd_q;
	logic                       rd_valid_q;
	entry_t                     cur;
	entry_t                     upd;
	logic signed [SAMPLE_W:0]   sum_c;
	logic signed [SAMPLE_W:0]   sum_adj;
	entry_t                     ent_q;

	// flags and divider
	logic signed [SAMPLE_W:0]   hc;
	logic signed [SAMPLE_W+1:0] thr;
	logic signed [SAMPLE_W+1:0] lim_lo;
	logic signed [SAMPLE_W+1:0] lim_hi;
	logic signed [SAMPLE_W+1:0] s_ext;
	logic signed [SAMPLE_W:0]   diff;
	logic        [SAMPLE_W:0]   diff_mag;
	logic        [SAMPLE_W:0]   span;
	logic                       neg_q;
	logic                       pos_q;
	logic                       num_neg_q;
	logic        [25:0]         rem_q;
	logic        [25:0]         dvs_q;
	logic        [ANALOG_W-1:0] quo_q;
	logic        [DIV_CNT_W-1:0] cnt_q;
	logic                       ge;

	// result
	logic        [ANALOG_W-1:0] mag;
	logic        [ANALOG_W-1:0] analog;
	logic        [OUT_TDATA_W-1:0] out_q;

	assign in_joy  = s_axis_tuser[JOY_W-1:0];
	assign in_axis = s_axis_tuser[JOY_W+AXIS_W-1:JOY_W];
	assign in_inv  = s_axis_tuser[JOY_W+AXIS_W];
	assign in_slot = SLOT_W'(int'(in_joy) * AXES_PER_JOYSTICK + int'(in_axis));

	assign sts.in_range  = (int'(in_joy) < NUM_JOYSTICKS) &&
	                       (int'(in_axis) < AXES_PER_JOYSTICK);
	assign sts.analog_en = analog_en_q;
	assign sts.div_last  = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			analog_en_q <= 1'b0;
		end else if (cfg_valid) begin
			analog_en_q <= cfg_data;
		end
	end

	// valid bits: unwritten entries read as reset calibration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.update) begin
			valid_q[slot_q] <= 1'b1;
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mem[slot_q] <= upd;
		end
		if (cmd.capture && sts.in_range) begin
			rd_q       <= mem[in_slot];
			rd_valid_q <= valid_q[in_slot];
		end
	end

	// capture input word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= s_axis_tdata[SAMPLE_W-1:0];
			inv_q    <= in_inv;
			oob_q    <= !sts.in_range;
			slot_q   <= in_slot;
		end
	end

	// bound update and center recompute, center truncated toward zero
	always_comb begin
		cur = rd_valid_q ? rd_q
		                 : entry_t'{lo: LOW_RESET, hi: HIGH_RESET, ctr: CENTER_RESET};
		upd = cur;
		if (sample_q > cur.hi) begin
			upd.hi = sample_q;
		end else if (sample_q < cur.lo) begin
			upd.lo = sample_q;
		end
		sum_c   = (SAMPLE_W+1)'(upd.hi) + (SAMPLE_W+1)'(upd.lo);
		sum_adj = sum_c + {{SAMPLE_W{1'b0}}, sum_c[SAMPLE_W]};
		if ((sample_q > cur.hi) || (sample_q < cur.lo)) begin
			upd.ctr = sum_adj[SAMPLE_W:1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			ent_q <= upd;
		end
	end

	// threshold window and scaled numerator
	always_comb begin
		hc       = (SAMPLE_W+1)'(ent_q.hi) - (SAMPLE_W+1)'(ent_q.ctr);
		thr      = {2'b00, hc[SAMPLE_W:1]};
		s_ext    = (SAMPLE_W+2)'(sample_q);
		lim_lo   = (SAMPLE_W+2)'(ent_q.ctr) - thr;
		lim_hi   = (SAMPLE_W+2)'(ent_q.ctr) + thr;
		diff     = (SAMPLE_W+1)'(sample_q) - (SAMPLE_W+1)'(ent_q.ctr);
		diff_mag = diff[SAMPLE_W] ? 17'(-diff) : 17'(diff);
		span     = 17'((SAMPLE_W+1)'(ent_q.hi) - (SAMPLE_W+1)'(ent_q.lo));
	end

	// restoring divide, one quotient bit per step
	assign ge = (rem_q >= dvs_q);

	always_ff @(posedge clk) begin
		if (cmd.flags) begin
			neg_q     <= (s_ext < lim_lo);
			pos_q     <= !(s_ext < lim_lo) && (s_ext > lim_hi);
			num_neg_q <= diff[SAMPLE_W];
			rem_q     <= 26'(diff_mag) * 26'(SCALE);
			dvs_q     <= {1'b0, span, 8'b0};
			quo_q     <= '0;
			cnt_q     <= '0;
		end else if (cmd.div_step) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q;
			end
			quo_q <= {quo_q[ANALOG_W-2:0], ge};
			dvs_q <= dvs_q >> 1;
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	// clamp, sign and invert; zero when analog mode is off
	always_comb begin
		mag    = (quo_q > CLAMP_MAG) ? CLAMP_MAG : quo_q;
		analog = (num_neg_q ^ inv_q) ? ANALOG_W'(-mag) : mag;
		if (!analog_en_q) begin
			analog = '0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (oob_q) begin
				out_q <= '0;
			end else begin
				out_q <= OUT_TDATA_W'({analog, pos_q, neg_q});
			end
		end
	end

	assign m_axis_tdata = out_q;

endmodule

`default_nettype wire

### design/autocal_axis_direction_and_analog_top.sv
// Auto-calibrating joystick axis. Each input word carries one signed 16-bit
// reading for one axis of one joystick; the block tracks a running minimum,
// maximum and center for that axis (reset -10, 10, 0), widens a bound when the
// reading passes it, and returns direction flags against a window of half the
// upper half-range around the center. With analog mode set through the cfg
// channel it also returns (sample-center)*257/(max-min), truncated toward
// zero, clamped to -128..128 and optionally negated. One item is in flight at
// a time: memory read, bound update, flag stage and a 9-step restoring
// divider with analog mode on, the divider skipped with it off, and a zero
// result with no state change for an out-of-range joystick or axis index.
// The output register lets the next word be taken while a result waits.
`default_nettype none

module autocal_axis_direction_and_analog_top
	import acad_pkg::*;
#(
	parameter int NUM_JOYSTICKS     = 4,
	parameter int AXES_PER_JOYSTICK = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample[15:0]
	input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,  // joystick_index[1:0], axis_index[4:2], invert[5]
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // dir_negative[0], dir_positive[1], analog_value[10:2], zero[15:11]
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic                   cfg_data       // analog_enable
);

	acad_cmd_t cmd;
	acad_sts_t sts;

	assign cfg_ready = 1'b1;

	acad_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	acad_datapath #(
		.NUM_JOYSTICKS     (NUM_JOYSTICKS),
		.AXES_PER_JOYSTICK (AXES_PER_JOYSTICK)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

`default_nettype wire

### test/axis_cal_checker.sv
module axis_cal_checker
	import acad_pkg::*;
#(
	parameter int NUM_JOYSTICKS     = 4,
	parameter int AXES_PER_JOYSTICK = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample[15:0]
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // joystick_index[1:0], axis_index[4:2], invert[5]
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // dir_negative[0], dir_positive[1], analog_value[10:2], zero[15:11]
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic                   cfg_data,
	output int                     mismatches,
	output int                     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS        = NUM_JOYSTICKS * AXES_PER_JOYSTICK;
	localparam int SCALE_NUM    = 257;
	localparam int ANALOG_LIMIT = 128;

	typedef struct packed {
		logic                       dir_negative;
		logic                       dir_positive;
		logic signed [ANALOG_W-1:0] analog_value;
	} axis_result_t;

	// calibration copy, one entry per joystick axis
	logic signed [SAMPLE_W-1:0] low_bound  [SLOTS];
	logic signed [SAMPLE_W-1:0] high_bound [SLOTS];
	logic signed [SAMPLE_W-1:0] center_pos [SLOTS];
	logic                       analog_on;

	axis_result_t predicted_results[$];
	int           mismatch_count = 0;

	assign mismatches = mismatch_count;

	// widen the bounds for one reading, then derive flags and analog value
	function automatic axis_result_t calibrate_reading(
		logic [JOY_W-1:0] joy, logic [AXIS_W-1:0] ax,
		logic signed [SAMPLE_W-1:0] smp, logic inv);
		axis_result_t r;
		int slot, lo, hi, ctr, thr, span, s, a;
		r = '0;
		if (joy >= NUM_JOYSTICKS || ax >= AXES_PER_JOYSTICK)
			return r;
		slot = joy * AXES_PER_JOYSTICK + ax;
		s = smp;
		lo = low_bound[slot];
		hi = high_bound[slot];
		ctr = center_pos[slot];
		if (s > hi) begin
			hi = s;
			ctr = (hi + lo) / 2;
		end else if (s < lo) begin
			lo = s;
			ctr = (hi + lo) / 2;
		end
		low_bound[slot] = SAMPLE_W'(lo);
		high_bound[slot] = SAMPLE_W'(hi);
		center_pos[slot] = SAMPLE_W'(ctr);

		// window is half the upper half-range
		thr = (hi - ctr) / 2;
		if (s < ctr - thr)
			r.dir_negative = 1'b1;
		else if (s > ctr + thr)
			r.dir_positive = 1'b1;

		if (analog_on) begin
			span = hi - lo;
			a = ((s - ctr) * SCALE_NUM) / span;
			if (a < -ANALOG_LIMIT)
				a = -ANALOG_LIMIT;
			if (a > ANALOG_LIMIT)
				a = ANALOG_LIMIT;
			if (inv)
				a = -a;
			r.analog_value = ANALOG_W'(a);
		end
		return r;
	endfunction

	// compare one result word with the oldest prediction
	function automatic void check_result(logic [OUT_TDATA_W-1:0] word);
		axis_result_t want;
		if (predicted_results.size() == 0) begin
			$error("result word %h with no prediction pending", word);
			mismatch_count++;
			return;
		end
		want = predicted_results.pop_front();
		if (word[0] !== want.dir_negative) begin
			$error("dir_negative: expected %0d, got %0d", want.dir_negative, word[0]);
			mismatch_count++;
		end
		if (word[1] !== want.dir_positive) begin
			$error("dir_positive: expected %0d, got %0d", want.dir_positive, word[1]);
			mismatch_count++;
		end
		if (word[ANALOG_W+1:2] !== want.analog_value) begin
			$error("analog_value: expected %0d, got %0d", want.analog_value,
				$signed(word[ANALOG_W+1:2]));
			mismatch_count++;
		end
		if (word[OUT_TDATA_W-1:ANALOG_W+2] !== '0) begin
			$error("tdata padding: expected 0, got %h", word[OUT_TDATA_W-1:ANALOG_W+2]);
			mismatch_count++;
		end
	endfunction

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) begin
				low_bound[k] = LOW_RESET;
				high_bound[k] = HIGH_RESET;
				center_pos[k] = CENTER_RESET;
			end
			analog_on = 1'b0;
			predicted_results.delete();
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				predicted_results.push_back(calibrate_reading(s_axis_tuser[1:0],
					s_axis_tuser[4:2], s_axis_tdata, s_axis_tuser[5]));
			if (cfg_valid && cfg_ready)
				analog_on = cfg_data;
			outstanding <= predicted_results.size();
		end
	end

endmodule

### test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import acad_pkg::*;

	localparam int JOYSTICKS      = 4;
	localparam int AXES           = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 40;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // sample[15:0]
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // joystick_index[1:0], axis_index[4:2], invert[5]
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // dir_negative[0], dir_positive[1], analog_value[10:2]
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_data = 1'b0;

	int mismatches;
	int outstanding;
	int idle_pct = 0;
	int stall_pct = 0;
	int words_sent = 0;
	int cfg_writes = 0;
	int quiet_cycles = 0;

	autocal_axis_direction_and_analog_top #(
		.NUM_JOYSTICKS(JOYSTICKS),
		.AXES_PER_JOYSTICK(AXES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	axis_cal_checker #(
		.NUM_JOYSTICKS(JOYSTICKS),
		.AXES_PER_JOYSTICK(AXES)
	) cal_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// sink back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// give up after a long stretch with no word moving on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("no word moved for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, outstanding);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// reach widens over the run so the bounds grow step by step
	function automatic logic [SAMPLE_W-1:0] random_sample();
		int pick, reach;
		pick = $urandom_range(99);
		reach = 20 + words_sent * 20;
		if (reach > 32767)
			reach = 32767;
		if (pick < 4)
			return $urandom_range(1) ? 16'h7fff : 16'h8000;
		else if (pick < 8)
			return SAMPLE_W'($urandom);
		else if (pick < 20)
			return SAMPLE_W'(int'($urandom_range(16)) - 8);
		else
			return SAMPLE_W'(int'($urandom_range(2 * reach)) - reach);
	endfunction

	task automatic send_word(input logic [JOY_W-1:0] joy, input logic [AXIS_W-1:0] ax,
			input logic [SAMPLE_W-1:0] smp, input logic inv);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		s_axis_tuser <= {inv, ax, joy};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		words_sent++;
	endtask

	// hold the source until every predicted result has come back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_analog_enable(input logic value);
		drain_results();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	task automatic run_phase(input logic analog, input int idle, input int stall, input int n);
		idle_pct = idle;
		stall_pct = stall;
		write_analog_enable(analog);
		repeat (n) begin
			send_word(JOY_W'($urandom_range(3)), AXIS_W'($urandom_range(7)), random_sample(),
				1'($urandom_range(1)));
			if ($urandom_range(63) == 0)
				drain_results();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fresh axes, clamps, window edges, full-scale readings
		write_analog_enable(1'b1);
		send_word(2'd0, 3'd0, 16'sd11, 1'b0);      // widen high, clamp at +128
		send_word(2'd0, 3'd0, 16'sd11, 1'b1);      // inverted clamp
		send_word(2'd0, 3'd1, -16'sd11, 1'b0);     // widen low, clamp at -128
		send_word(2'd0, 3'd1, -16'sd11, 1'b1);     // -128 inverted gives 128
		send_word(2'd0, 3'd2, 16'sd0, 1'b0);       // dead center
		send_word(2'd0, 3'd2, 16'sd5, 1'b0);       // on the upper window edge
		send_word(2'd0, 3'd2, 16'sd6, 1'b0);
		send_word(2'd0, 3'd2, -16'sd5, 1'b1);      // on the lower window edge
		send_word(2'd0, 3'd2, -16'sd6, 1'b1);
		send_word(2'd3, 3'd7, 16'sh7fff, 1'b0);    // largest reading
		send_word(2'd3, 3'd7, 16'sh8000, 1'b1);    // smallest reading, widest span
		send_word(2'd3, 3'd7, 16'sd0, 1'b0);
		send_word(2'd3, 3'd7, 16'sd16384, 1'b1);
		send_word(2'd3, 3'd7, -16'sd16384, 1'b0);
		send_word(2'd3, 3'd7, -16'sd16385, 1'b0);
		send_word(2'd2, 3'd5, 16'sh8000, 1'b0);    // low side first on a fresh axis
		send_word(2'd2, 3'd5, -16'sd1, 1'b1);
		send_word(2'd1, 3'd3, 16'sh7fff, 1'b1);
		send_word(2'd1, 3'd4, 16'sd12345, 1'b0);
		send_word(2'd2, 3'd6, -16'sd1, 1'b1);
		send_word(2'd1, 3'd0, -16'sd20, 1'b0);
		send_word(2'd1, 3'd0, 16'sd10, 1'b0);      // equal to the reset maximum

		// random phases: analog off and on, each flow-control mix
		run_phase(1'b0, 0, 0, 300);
		run_phase(1'b1, 60, 0, 300);
		run_phase(1'b1, 0, 60, 300);
		run_phase(1'b0, 19, 19, 300);
		run_phase(1'b1, 19, 19, 400);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d sample words over %0d axes with %0d analog-mode writes,",
			words_sent, JOYSTICKS * AXES, cfg_writes);
		$display("under no flow control, source gaps, sink stalls and both together.");
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
